/* rtl/core/ctds_pkg.sv */
package ctds_pkg;

   localparam int TASKS = 8;
   localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int CNT_W = $clog2(TASKS + 1);

   localparam logic [1:0] KIND_REGISTER = 2'd0;
   localparam logic [1:0] KIND_DISPATCH = 2'd1;
   localparam logic [1:0] KIND_COMPLETE = 2'd2;
   localparam logic [1:0] KIND_ALARM    = 2'd3;

   localparam logic [1:0] ST_STOPPED = 2'd0;
   localparam logic [1:0] ST_READY   = 2'd1;
   localparam logic [1:0] ST_WAITING = 2'd2;
   localparam logic [1:0] ST_BLOCKED = 2'd3;

   localparam logic CSR_MIN_WAIT = 1'b0;
   localparam logic CSR_MAX_WAIT = 1'b1;

   // command from controller to datapath
   typedef struct packed {
      logic             load;      // capture request, reset scan regs
      logic             scan;      // process slot at scan index
      logic             sweep;     // second alarm pass: subtract best
      logic             finish;    // commit result register
      logic [CNT_W-1:0] step;      // scan position
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
   } stat_type;

endpackage

/* rtl/core/ctds_if.sv */
interface ctds_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [2:0]  task_index;
   logic [1:0]  returned_state;
   logic [15:0] wait_time;
   modport source (output valid, kind, task_index, returned_state, wait_time, input ready);
   modport sink (input valid, kind, task_index, returned_state, wait_time, output ready);
endinterface

interface ctds_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  slot;
   logic        slot_valid;
   logic [15:0] alarm_length;
   logic        alarm_set;
   logic [7:0]  woken_mask;
   modport source (output valid, slot, slot_valid, alarm_length, alarm_set, woken_mask,
                   input ready);
   modport sink (input valid, slot, slot_valid, alarm_length, alarm_set, woken_mask,
                 output ready);
endinterface

interface ctds_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/ctds_ctrl.sv */
module ctds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic                 rsp_busy,
   input  ctds_pkg::stat_type   stat,
   output logic                 req_ready,
   output ctds_pkg::cmd_type    cmd
);
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SWEEP = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [ctds_pkg::CNT_W-1:0] step_ff, step_in;
   logic                       last;

   assign last = (step_ff == ctds_pkg::CNT_W'(ctds_pkg::TASKS - 1));
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cmd = '0;
      cmd.step = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               // every kind walks the table, alarm twice; completion grows other waiters
               state_in = S_SCAN;
               step_in = '0;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            step_in = step_ff + 1'b1;
            if (last) begin
               step_in = '0;
               state_in = (stat.kind == ctds_pkg::KIND_ALARM) ? S_SWEEP : S_DONE;
            end
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            step_in = step_ff + 1'b1;
            if (last) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_busy) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

`ifndef SYNTHESIS
   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_SWEEP)
         |-> step_ff < ctds_pkg::CNT_W'(ctds_pkg::TASKS)) else $error("step overrun");
   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == S_IDLE) else $error("load outside idle");
   a_finish_returns: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> state_ff == S_IDLE) else $error("finish did not return");
`endif
endmodule

/* rtl/core/ctds_dp.sv */
module ctds_dp (
   input  logic               clock,
   input  logic               reset,
   input  ctds_pkg::cmd_type  cmd,
   output ctds_pkg::stat_type stat,
   input  logic [1:0]         req_kind,
   input  logic [2:0]         req_task_index,
   input  logic [1:0]         req_returned_state,
   input  logic [15:0]        req_wait_time,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_data,
   input  logic               rsp_take,
   output logic               rsp_valid,
   output logic [2:0]         rsp_slot,
   output logic               rsp_slot_valid,
   output logic [15:0]        rsp_alarm_length,
   output logic               rsp_alarm_set,
   output logic [7:0]         rsp_woken_mask
);
   localparam int N = ctds_pkg::TASKS;
   localparam int IW = ctds_pkg::IDX_W;

   logic [1:0]  st_ff [N];
   logic [15:0] off_ff [N];
   logic [15:0] timer_ff, min_ff, max_ff;
   logic [IW-1:0] cur_ff;

   logic [1:0]  kind_ff;
   logic [2:0]  idx_ff;
   logic [1:0]  rst_ff;
   logic [15:0] wait_ff;

   logic          found_ff;
   logic [IW-1:0] fslot_ff;
   logic          any_ff;
   logic [15:0]   best_ff;
   logic [7:0]    mask_ff;

   logic          ov_ff;
   logic [2:0]    os_ff;
   logic          osv_ff;
   logic [15:0]   ol_ff;
   logic          oset_ff;
   logic [7:0]    om_ff;

   logic [IW-1:0] sidx, didx, cidx;
   logic [IW:0]   dsum;
   logic          cidx_ok;
   logic [15:0]   diff;
   logic          wait_in_range, shorter, wait_first;
   logic [16:0]   grown;

   assign stat.kind = kind_ff;
   assign sidx = cmd.step[IW-1:0];
   assign dsum = {1'b0, cur_ff} + {1'b0, sidx};
   assign didx = (dsum >= (IW+1)'(N)) ? IW'(dsum - (IW+1)'(N)) : dsum[IW-1:0];
   assign cidx_ok = ({29'd0, idx_ff} < 32'(N));
   assign cidx = IW'(idx_ff);
   assign wait_in_range = (wait_ff >= min_ff) && (wait_ff <= max_ff);
   assign shorter = (timer_ff == 16'd0) || (timer_ff >= wait_ff);
   // accepted wait that restarts the timer
   assign wait_first = cidx_ok && (rst_ff == ctds_pkg::ST_WAITING) && wait_in_range
                       && shorter;
   assign diff = (timer_ff == 16'd0) ? 16'd0 : timer_ff - wait_ff;
   assign grown = {1'b0, off_ff[sidx]} + {1'b0, diff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            st_ff[i] <= ctds_pkg::ST_STOPPED;
            off_ff[i] <= '0;
         end
         timer_ff <= '0;
         cur_ff <= '0;
         min_ff <= 16'd1;
         max_ff <= 16'hffff;
         ov_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == ctds_pkg::CSR_MIN_WAIT) min_ff <= csr_data;
            else max_ff <= csr_data;
         end
         if (cmd.finish) ov_ff <= 1'b1;
         else if (rsp_take) ov_ff <= 1'b0;
         if (cmd.load) begin
            kind_ff <= req_kind;
            idx_ff <= req_task_index;
            rst_ff <= req_returned_state;
            wait_ff <= req_wait_time;
            found_ff <= 1'b0;
            fslot_ff <= '0;
            any_ff <= 1'b0;
            best_ff <= '0;
            mask_ff <= '0;
         end
         if (cmd.scan) begin
            unique case (kind_ff)
               ctds_pkg::KIND_REGISTER: begin
                  if (!found_ff && st_ff[sidx] == ctds_pkg::ST_STOPPED) begin
                     found_ff <= 1'b1;
                     fslot_ff <= sidx;
                     st_ff[sidx] <= ctds_pkg::ST_READY;
                     off_ff[sidx] <= '0;
                  end
               end
               ctds_pkg::KIND_DISPATCH: begin
                  if (!found_ff && st_ff[didx] == ctds_pkg::ST_READY) begin
                     found_ff <= 1'b1;
                     fslot_ff <= didx;
                  end
               end
               ctds_pkg::KIND_ALARM: begin
                  if (st_ff[sidx] == ctds_pkg::ST_WAITING) begin
                     if (off_ff[sidx] < min_ff) begin
                        st_ff[sidx] <= ctds_pkg::ST_READY;
                        if ({{(32-IW){1'b0}}, sidx} < 32'd8)
                           mask_ff[sidx[2:0]] <= 1'b1;
                     end else if (!any_ff || off_ff[sidx] < best_ff) begin
                        any_ff <= 1'b1;
                        best_ff <= off_ff[sidx];
                     end
                  end
               end
               // completion: grow other waiters when the new wait goes first
               default: begin
                  if (cidx_ok && rst_ff == ctds_pkg::ST_WAITING && wait_in_range
                      && timer_ff != 16'd0 && timer_ff >= wait_ff && sidx != cidx
                      && st_ff[sidx] == ctds_pkg::ST_WAITING)
                     off_ff[sidx] <= grown[16] ? 16'hffff : grown[15:0];
               end
            endcase
         end
         if (cmd.sweep && any_ff && st_ff[sidx] == ctds_pkg::ST_WAITING)
            off_ff[sidx] <= off_ff[sidx] - best_ff;
         if (cmd.finish) begin
            unique case (kind_ff)
               ctds_pkg::KIND_REGISTER, ctds_pkg::KIND_DISPATCH: begin
                  osv_ff <= found_ff;
                  os_ff <= found_ff ? 3'({{(32-IW){1'b0}}, fslot_ff}) : 3'd0;
                  ol_ff <= '0;
                  oset_ff <= 1'b0;
                  om_ff <= '0;
                  if (kind_ff == ctds_pkg::KIND_DISPATCH && found_ff)
                     cur_ff <= (fslot_ff == IW'(N - 1)) ? '0 : fslot_ff + 1'b1;
               end
               ctds_pkg::KIND_ALARM: begin
                  os_ff <= '0;
                  osv_ff <= 1'b0;
                  om_ff <= mask_ff;
                  timer_ff <= any_ff ? best_ff : 16'd0;
                  ol_ff <= any_ff ? best_ff : 16'd0;
                  oset_ff <= any_ff;
               end
               default: begin
                  os_ff <= '0;
                  osv_ff <= 1'b0;
                  om_ff <= '0;
                  ol_ff <= wait_first ? wait_ff : 16'd0;
                  oset_ff <= wait_first;
                  if (cidx_ok) begin
                     // out-of-range wait makes the task ready
                     st_ff[cidx] <= (rst_ff == ctds_pkg::ST_WAITING && !wait_in_range)
                                    ? ctds_pkg::ST_READY : rst_ff;
                     if (wait_first) begin
                        off_ff[cidx] <= '0;
                        timer_ff <= wait_ff;
                     end else if (rst_ff == ctds_pkg::ST_WAITING && wait_in_range) begin
                        off_ff[cidx] <= wait_ff - timer_ff;
                     end
                  end
               end
            endcase
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_slot = os_ff;
   assign rsp_slot_valid = osv_ff;
   assign rsp_alarm_length = ol_ff;
   assign rsp_alarm_set = oset_ff;
   assign rsp_woken_mask = om_ff;

`ifndef SYNTHESIS
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid) else $error("finish without response");
   a_no_finish_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!ov_ff || rsp_take)) else $error("response overwritten");
   a_set_nonalarm_nomask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_slot_valid) |-> (!rsp_alarm_set && rsp_woken_mask == 8'd0))
      else $error("mixed response");
`endif
endmodule

/* rtl/core/coop_task_delta_timer_scheduler.sv */
// cooperative task scheduler with a delta-timer wait queue. one request is
// handled at a time: every request walks the task table one slot per cycle
// (alarm walks it twice: find/wake, then subtract the new timer; completion
// uses its walk to push other waiters later). the result sits in an output
// register, so the next request is taken while it waits.
// csr index 0 is min_wait, 1 is max_wait; write only while idle.
module coop_task_delta_timer_scheduler (
   input logic        clock,
   input logic        reset,
   ctds_req_if.sink   req,
   ctds_rsp_if.source rsp,
   ctds_csr_if.sink   csr
);
   ctds_pkg::cmd_type  cmd;
   ctds_pkg::stat_type stat;
   logic               req_fire;
   logic               rsp_busy;

   assign req_fire = req.valid && req.ready;
   // output register still full and not being taken
   assign rsp_busy = rsp.valid && !rsp.ready;
   assign csr.ready = 1'b1;

   // controller: sequences the table walk
   ctds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .rsp_busy  (rsp_busy),
      .stat      (stat),
      .req_ready (req.ready),
      .cmd       (cmd)
   );

   // datapath: task table, timer, result register
   ctds_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_kind           (req.kind),
      .req_task_index     (req.task_index),
      .req_returned_state (req.returned_state),
      .req_wait_time      (req.wait_time),
      .csr_we             (csr.valid && csr.ready),
      .csr_index          (csr.index),
      .csr_data           (csr.data),
      .rsp_take           (rsp.valid && rsp.ready),
      .rsp_valid          (rsp.valid),
      .rsp_slot           (rsp.slot),
      .rsp_slot_valid     (rsp.slot_valid),
      .rsp_alarm_length   (rsp.alarm_length),
      .rsp_alarm_set      (rsp.alarm_set),
      .rsp_woken_mask     (rsp.woken_mask)
   );
endmodule
